>>> sv/slcm_pkg.sv
package slcm_pkg;

	localparam int SAMPLE_W        = 24;
	localparam int LEVEL_W         = 24;
	localparam int CORR_W          = 16;
	localparam int CORR_MAG_W      = 15;
	localparam int CORR_SHIFT      = 28;
	localparam int LIMB_W          = 32;
	localparam int MAX_BLOCK_DEF   = 4096;
	localparam int SAMPLE_BITS_DEF = 24;
	localparam int IN_W            = 2 * SAMPLE_W;
	localparam int OUT_W           = 4 * LEVEL_W + CORR_W;

	typedef struct packed {
		logic acc;
		logic fin;
	} slcm_ctl_t;

	typedef struct packed {
		logic busy;
		logic zero;
	} slcm_stat_t;

	// sum of squares over a full block
	function automatic int energy_w(input int max_block);
		return 2 * SAMPLE_W - 1 + $clog2(max_block + 1);
	endfunction

	function automatic int count_w(input int max_block);
		return $clog2(max_block + 1);
	endfunction

endpackage

>>> sv/slcm_lane.sv
module slcm_lane #(
	parameter int MAX_BLOCK   = slcm_pkg::MAX_BLOCK_DEF,
	parameter int SAMPLE_BITS = slcm_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                             clk,
	input  logic                                             arst_n,
	input  logic                                             take,
	input  slcm_pkg::slcm_ctl_t                              ctl,
	input  logic signed [slcm_pkg::SAMPLE_W-1:0]             sample,
	input  logic [slcm_pkg::count_w(MAX_BLOCK)-1:0]          count,
	output logic signed [slcm_pkg::SAMPLE_W-1:0]             sample_m,
	output logic [slcm_pkg::energy_w(MAX_BLOCK)-1:0]         energy,
	output logic [slcm_pkg::LEVEL_W-1:0]                     rms,
	output logic [slcm_pkg::LEVEL_W-1:0]                     peak,
	output slcm_pkg::slcm_stat_t                             stat
);
	import slcm_pkg::*;

	localparam int EW  = energy_w(MAX_BLOCK);
	localparam int CW  = count_w(MAX_BLOCK);
	localparam int SW  = $clog2(EW);
	localparam int QW  = 2 * LEVEL_W;
	localparam int RMW = LEVEL_W + 2;
	localparam logic [SAMPLE_W-1:0] KEEP =
		SAMPLE_W'({SAMPLE_BITS{1'b1}}) << (SAMPLE_W - SAMPLE_BITS);

	typedef enum logic [1:0] {L_IDLE, L_DIV, L_SQRT} lstate_t;

	lstate_t               st_q;
	logic [SW-1:0]         step_q;
	logic [2*SAMPLE_W-1:0] sq_s1;
	logic [SAMPLE_W-1:0]   a_s1;
	logic [SAMPLE_W-1:0]   mag;
	logic [EW-1:0]         acc_q;
	logic [EW-1:0]         tot_q;
	logic [EW-1:0]         esum;
	logic [LEVEL_W-1:0]    pk_q;
	logic [LEVEL_W-1:0]    pkf_q;
	logic [LEVEL_W-1:0]    pk_nx;
	logic [EW-1:0]         dvd_q;
	logic [CW-1:0]         rem_q;
	logic [CW-1:0]         dsr_q;
	logic [CW:0]           remx;
	logic                  ge_d;
	logic [CW-1:0]         rem_nx;
	logic [RMW-1:0]        rm_q;
	logic [LEVEL_W-1:0]    rt_q;
	logic [RMW+1:0]        rmx;
	logic [RMW+1:0]        trial;
	logic                  ge_r;
	logic [RMW-1:0]        rm_nx;

	assign sample_m = $signed(sample & KEEP);
	assign mag      = sample_m[SAMPLE_W-1] ? SAMPLE_W'(0) - sample_m : sample_m;
	assign esum     = acc_q + EW'(sq_s1);
	assign pk_nx    = (a_s1 > pk_q) ? a_s1 : pk_q;

	// restoring divide, one quotient bit per cycle
	assign remx   = {rem_q, dvd_q[EW-1]};
	assign ge_d   = remx >= {1'b0, dsr_q};
	assign rem_nx = ge_d ? CW'(remx - {1'b0, dsr_q}) : remx[CW-1:0];

	// digit-by-digit square root, one root bit per cycle
	assign rmx   = {rm_q, dvd_q[QW-1 -: 2]};
	assign trial = {2'b00, rt_q, 2'b01};
	assign ge_r  = rmx >= trial;
	assign rm_nx = ge_r ? RMW'(rmx - trial) : rmx[RMW-1:0];

	always_ff @(posedge clk) begin
		if (take) begin
			sq_s1 <= mag * mag;
			a_s1  <= mag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			pk_q  <= '0;
			tot_q <= '0;
			pkf_q <= '0;
		end else if (ctl.fin) begin
			tot_q <= esum;
			pkf_q <= pk_nx;
			acc_q <= '0;
			pk_q  <= '0;
		end else if (ctl.acc) begin
			acc_q <= esum;
			pk_q  <= pk_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= L_IDLE;
			step_q <= '0;
		end else begin
			unique case (st_q)
				L_IDLE: begin
					if (ctl.fin) begin
						step_q <= SW'(EW - 1);
						st_q   <= L_DIV;
					end
				end
				L_DIV: begin
					if (step_q == '0) begin
						step_q <= SW'(LEVEL_W - 1);
						st_q   <= L_SQRT;
					end else begin
						step_q <= step_q - SW'(1);
					end
				end
				L_SQRT: begin
					if (step_q == '0) begin
						st_q <= L_IDLE;
					end else begin
						step_q <= step_q - SW'(1);
					end
				end
				default: st_q <= L_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			L_IDLE: begin
				if (ctl.fin) begin
					dvd_q <= esum;
					rem_q <= '0;
					dsr_q <= count;
					rm_q  <= '0;
					rt_q  <= '0;
				end
			end
			L_DIV: begin
				rem_q <= rem_nx;
				dvd_q <= {dvd_q[EW-2:0], ge_d};
			end
			L_SQRT: begin
				dvd_q <= dvd_q << 2;
				rm_q  <= rm_nx;
				rt_q  <= {rt_q[LEVEL_W-2:0], ge_r};
			end
			default: ;
		endcase
	end

	assign energy    = tot_q;
	assign rms       = rt_q;
	assign peak      = pkf_q;
	assign stat.busy = st_q != L_IDLE;
	assign stat.zero = tot_q == '0;

endmodule

>>> sv/slcm_corr.sv
module slcm_corr #(
	parameter int MAX_BLOCK = slcm_pkg::MAX_BLOCK_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     take,
	input  slcm_pkg::slcm_ctl_t                      ctl,
	input  logic signed [slcm_pkg::SAMPLE_W-1:0]     left,
	input  logic signed [slcm_pkg::SAMPLE_W-1:0]     right,
	input  logic [slcm_pkg::energy_w(MAX_BLOCK)-1:0] el,
	input  logic [slcm_pkg::energy_w(MAX_BLOCK)-1:0] er,
	output logic [slcm_pkg::CORR_MAG_W-1:0]          mag,
	output logic                                     neg,
	output logic                                     busy
);
	import slcm_pkg::*;

	localparam int EW = energy_w(MAX_BLOCK);
	localparam int XW = EW + 1;
	localparam int LN = (EW + LIMB_W - 1) / LIMB_W;
	localparam int OW = LN * LIMB_W;
	localparam int PW = 2 * OW;
	localparam int IW = $clog2(LN);
	localparam int AW = PW + CORR_SHIFT + 4;
	localparam int BW = $clog2(CORR_MAG_W);

	typedef enum logic [2:0] {
		C_IDLE, C_MULP, C_MULQ, C_DRAIN, C_INIT, C_SUM, C_CMP
	} cstate_t;

	cstate_t                  st_q;
	logic signed [2*SAMPLE_W-1:0] prod_s1;
	logic signed [XW-1:0]     xacc_q;
	logic signed [XW-1:0]     xsum;
	logic [XW-1:0]            xabs;
	logic [EW-1:0]            c_q;
	logic                     neg_q;
	logic [IW-1:0]            i_q;
	logic [IW-1:0]            j_q;
	logic [OW-1:0]            opa;
	logic [OW-1:0]            opb;
	logic                     issue;
	logic                     last_pair;
	logic [2*LIMB_W-1:0]      pp_s1;
	logic [IW:0]              sh_s1;
	logic                     pv_s1;
	logic                     tgt_s1;
	logic [PW-1:0]            pp_sh;
	logic [PW-1:0]            p_q;
	logic [PW-1:0]            q_q;
	logic [AW-1:0]            d_q;
	logic [AW-1:0]            pb_q;
	logic [AW-1:0]            xb_q;
	logic [AW-1:0]            t_q;
	logic [AW-1:0]            u_q;
	logic [CORR_MAG_W-1:0]    m_q;
	logic [BW-1:0]            bit_q;
	logic                     take_bit;

	assign xsum      = xacc_q + XW'(prod_s1);
	assign xabs      = xsum[XW-1] ? XW'(0) - xsum : xsum;
	assign issue     = (st_q == C_MULP) || (st_q == C_MULQ);
	assign last_pair = (i_q == IW'(LN - 1)) && (j_q == IW'(LN - 1));
	assign opa       = (st_q == C_MULQ) ? OW'(c_q) : OW'(el);
	assign opb       = (st_q == C_MULQ) ? OW'(c_q) : OW'(er);
	assign pp_sh     = PW'(pp_s1) << (sh_s1 * LIMB_W);
	assign take_bit  = (d_q >= t_q) && !m_q[CORR_MAG_W-1];

	always_ff @(posedge clk) begin
		if (take) begin
			prod_s1 <= left * right;
		end
		pp_s1 <= opa[i_q*LIMB_W +: LIMB_W] * opb[j_q*LIMB_W +: LIMB_W];
		sh_s1 <= (IW+1)'(i_q) + (IW+1)'(j_q);
		tgt_s1 <= st_q == C_MULQ;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xacc_q <= '0;
		end else if (ctl.fin) begin
			xacc_q <= '0;
		end else if (ctl.acc) begin
			xacc_q <= xsum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= C_IDLE;
			i_q   <= '0;
			j_q   <= '0;
			pv_s1 <= 1'b0;
			bit_q <= '0;
		end else begin
			pv_s1 <= issue;
			unique case (st_q)
				C_IDLE: begin
					if (ctl.fin) begin
						i_q  <= '0;
						j_q  <= '0;
						st_q <= C_MULP;
					end
				end
				C_MULP, C_MULQ: begin
					if (last_pair) begin
						i_q  <= '0;
						j_q  <= '0;
						st_q <= (st_q == C_MULP) ? C_MULQ : C_DRAIN;
					end else if (j_q == IW'(LN - 1)) begin
						j_q <= '0;
						i_q <= i_q + IW'(1);
					end else begin
						j_q <= j_q + IW'(1);
					end
				end
				C_DRAIN: st_q <= C_INIT;
				C_INIT: begin
					bit_q <= BW'(CORR_MAG_W - 1);
					st_q  <= C_SUM;
				end
				C_SUM: st_q <= C_CMP;
				C_CMP: begin
					if (bit_q == '0) begin
						st_q <= C_IDLE;
					end else begin
						bit_q <= bit_q - BW'(1);
						st_q  <= C_SUM;
					end
				end
				default: st_q <= C_IDLE;
			endcase
		end
	end

	// find largest m with m*m*el*er <= 2^28*c*c using shift-add updates only
	always_ff @(posedge clk) begin
		case (st_q)
			C_IDLE: begin
				if (ctl.fin) begin
					c_q   <= xabs[EW-1:0];
					neg_q <= xsum[XW-1];
					p_q   <= '0;
					q_q   <= '0;
				end
			end
			C_INIT: begin
				d_q  <= AW'(q_q) << CORR_SHIFT;
				pb_q <= AW'(p_q) << CORR_SHIFT;
				xb_q <= '0;
				m_q  <= '0;
			end
			C_SUM: begin
				t_q <= xb_q + pb_q;
				u_q <= xb_q + (pb_q << 1);
			end
			C_CMP: begin
				if (take_bit) begin
					d_q  <= d_q - t_q;
					xb_q <= u_q >> 1;
					m_q  <= m_q | (CORR_MAG_W'(1) << bit_q);
				end else begin
					xb_q <= xb_q >> 1;
				end
				pb_q <= pb_q >> 2;
			end
			default: ;
		endcase
		if (pv_s1) begin
			if (tgt_s1) begin
				q_q <= q_q + pp_sh;
			end else begin
				p_q <= p_q + pp_sh;
			end
		end
	end

	assign mag  = m_q;
	assign neg  = neg_q;
	assign busy = st_q != C_IDLE;

endmodule

>>> sv/stereo_level_correlation_meter.sv
// channel    | dir | beat contents
// s_axis     | in  | tdata: left_sample, right_sample; tlast: last_in_block
// m_axis     | out | tdata: rms_left, rms_right, peak_left, peak_right, correlation
// cfg        | in  | cfg_wdata: channel_count, written when cfg_wen is high
//
// samples inside a block are taken one per cycle
// a block end runs a divide then a square root in each lane;
// the correlation search runs alongside them
// input stalls until the result loads; a finished result waits in the output register
// arst_n clears the accumulators, held levels and channel_count to stereo
module stereo_level_correlation_meter #(
	parameter int MAX_BLOCK   = slcm_pkg::MAX_BLOCK_DEF,
	parameter int SAMPLE_BITS = slcm_pkg::SAMPLE_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wen,
	input  logic [1:0]                 cfg_wdata,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [slcm_pkg::IN_W-1:0]  s_axis_tdata,   // left_sample, right_sample
	input  logic                       s_axis_tlast,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [slcm_pkg::OUT_W-1:0] m_axis_tdata    // rms_l, rms_r, peak_l, peak_r, corr
);
	import slcm_pkg::*;

	localparam int EW = energy_w(MAX_BLOCK);
	localparam int CW = count_w(MAX_BLOCK);
	localparam int CORR_ONE = 16384;
	localparam logic [1:0] CHAN_LEFT   = 2'd1;
	localparam logic [1:0] CHAN_STEREO = 2'd2;

	typedef enum logic {ST_ACC, ST_CALC} state_t;

	state_t                     st_q;
	logic [1:0]                 chan_q;
	logic [CW-1:0]              cnt_q;
	logic [CW-1:0]              cnt_nx;
	logic [CW-1:0]              n_s1;
	logic                       v_s1;
	logic                       end_s1;
	logic                       take;
	logic                       fin;
	logic                       blk_end;
	logic                       idle_all;
	logic                       load;
	logic                       corr_ok;
	logic [CORR_W-1:0]          corr_nx;
	slcm_ctl_t                  ctl;
	slcm_stat_t                 stat_l;
	slcm_stat_t                 stat_r;
	logic                       busy_c;
	logic signed [SAMPLE_W-1:0] sm_l;
	logic signed [SAMPLE_W-1:0] sm_r;
	logic [EW-1:0]              energy_l;
	logic [EW-1:0]              energy_r;
	logic [LEVEL_W-1:0]         rms_l;
	logic [LEVEL_W-1:0]         rms_r;
	logic [LEVEL_W-1:0]         pk_l;
	logic [LEVEL_W-1:0]         pk_r;
	logic [CORR_MAG_W-1:0]      mag;
	logic                       neg;
	logic                       out_v_q;
	logic [LEVEL_W-1:0]         rms_l_q;
	logic [LEVEL_W-1:0]         rms_r_q;
	logic [LEVEL_W-1:0]         pk_l_q;
	logic [LEVEL_W-1:0]         pk_r_q;
	logic signed [CORR_W-1:0]   corr_q;

	assign take          = s_axis_tvalid & s_axis_tready;
	assign fin           = v_s1 & end_s1;
	assign s_axis_tready = (st_q == ST_ACC) & ~fin;
	assign cnt_nx        = cnt_q + CW'(1);
	assign blk_end       = s_axis_tlast | (cnt_nx == CW'(MAX_BLOCK));
	assign ctl.acc       = v_s1;
	assign ctl.fin       = fin;
	assign idle_all      = ~stat_l.busy & ~stat_r.busy & ~busy_c;
	assign load          = (st_q == ST_CALC) & idle_all & (~out_v_q | m_axis_tready);
	assign corr_ok       = (chan_q >= CHAN_STEREO) & ~stat_l.zero & ~stat_r.zero;
	assign corr_nx       = !corr_ok ? '0 :
		(neg ? CORR_W'(0) - CORR_W'(mag) : CORR_W'(mag));

	slcm_lane #(
		.MAX_BLOCK   (MAX_BLOCK),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_lane_l (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.ctl      (ctl),
		.sample   (s_axis_tdata[SAMPLE_W-1:0]),
		.count    (n_s1),
		.sample_m (sm_l),
		.energy   (energy_l),
		.rms      (rms_l),
		.peak     (pk_l),
		.stat     (stat_l)
	);

	slcm_lane #(
		.MAX_BLOCK   (MAX_BLOCK),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_lane_r (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.ctl      (ctl),
		.sample   (s_axis_tdata[IN_W-1:SAMPLE_W]),
		.count    (n_s1),
		.sample_m (sm_r),
		.energy   (energy_r),
		.rms      (rms_r),
		.peak     (pk_r),
		.stat     (stat_r)
	);

	slcm_corr #(
		.MAX_BLOCK (MAX_BLOCK)
	) u_corr (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.ctl    (ctl),
		.left   (sm_l),
		.right  (sm_r),
		.el     (energy_l),
		.er     (energy_r),
		.mag    (mag),
		.neg    (neg),
		.busy   (busy_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q <= CHAN_STEREO;
		end else if (cfg_wen) begin
			chan_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			end_s1 <= 1'b0;
			n_s1   <= '0;
			cnt_q  <= '0;
		end else begin
			v_s1 <= take;
			if (take) begin
				end_s1 <= blk_end;
				n_s1   <= cnt_nx;
				cnt_q  <= blk_end ? '0 : cnt_nx;
			end
		end
	end

	// output register doubles as the held levels
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_ACC;
			out_v_q <= 1'b0;
			rms_l_q <= '0;
			rms_r_q <= '0;
			pk_l_q  <= '0;
			pk_r_q  <= '0;
			corr_q  <= '0;
		end else begin
			if (out_v_q && m_axis_tready && !load) begin
				out_v_q <= 1'b0;
			end
			unique case (st_q)
				ST_ACC: begin
					if (fin) begin
						st_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					if (load) begin
						out_v_q <= 1'b1;
						corr_q  <= corr_nx;
						if (chan_q >= CHAN_LEFT) begin
							rms_l_q <= rms_l;
							pk_l_q  <= pk_l;
						end
						if (chan_q >= CHAN_STEREO) begin
							rms_r_q <= rms_r;
							pk_r_q  <= pk_r;
						end
						st_q <= ST_ACC;
					end
				end
				default: st_q <= ST_ACC;
			endcase
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {corr_q, pk_r_q, pk_l_q, rms_r_q, rms_l_q};

`ifndef NO_ASSERTIONS
	a_fin_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fin |-> idle_all)
		else $error("block end while a finishing unit is still busy");

	a_fin_start: assert property (@(posedge clk) disable iff (!arst_n)
		fin |=> (stat_l.busy && stat_r.busy && busy_c))
		else $error("finishing units did not start on block end");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> m_axis_tvalid)
		else $error("result load did not raise output valid");

	a_corr_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (corr_q <= CORR_ONE && corr_q >= -CORR_ONE))
		else $error("correlation outside plus or minus one");
`endif

endmodule
